[design/qpht_pkg.sv]
// qpht_pkg: shared constants, codes and controller/datapath interface types
// for the quadratic probe hash table. No dependencies.

package qpht_pkg;

	localparam int SLOTS    = 1024;
	localparam int KEY_BITS = 31;

	localparam int SLOT_W  = $clog2(SLOTS);      // slot and probe index
	localparam int SUM_W   = SLOT_W + 1;         // slot arithmetic, holds n
	localparam int SIZE_W  = 11;                 // table_size register
	localparam int OUT_W   = 10;                 // slot_index / probe_count fields
	localparam int DCNT_W  = $clog2(KEY_BITS + 1);
	localparam int ENTRY_W = KEY_BITS + 1;       // {occupied, key}

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		logic    load;        // latch key, start modulo
		logic    div_run;     // one remainder bit
		logic    probe_init;  // slot = start = key mod n, i = 0
		logic    rd_en;       // read entry at current slot
		logic    advance;     // next probe
		logic    wr_insert;
		logic    wr_delete;
		logic    clr_wr;      // clear one entry after reset
		logic    out_load;    // load result register
		status_t res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic occ;
		logic match;
		logic at_start;
		logic first_probe;
		logic clr_last;
	} dp_stat_t;

endpackage

[design/qpht_ram.sv]
// qpht_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module qpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/qpht_dp.sv]
// qpht_dp: datapath of the hash table: table size register, bit-serial key
// modulo, probe slot arithmetic, entry RAM and result register.
// Depends on qpht_pkg and qpht_ram.

module qpht_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [qpht_pkg::SIZE_W-1:0] cfg_wdata,
	input  logic [31:0]                 s_axis_tdata,
	input  qpht_pkg::dp_cmd_t           cmd,
	output qpht_pkg::dp_stat_t          stat,
	output logic [23:0]                 m_axis_tdata,
	output logic [7:0]                  m_axis_tuser
);

	localparam int SLOT_W = qpht_pkg::SLOT_W;
	localparam int SUM_W  = qpht_pkg::SUM_W;
	localparam int KB     = qpht_pkg::KEY_BITS;

	logic [qpht_pkg::SIZE_W-1:0] table_size_q;
	logic [SUM_W-1:0]            n;

	logic [KB-1:0]               key_q;
	logic [KB-1:0]               key_sh_q;
	logic [SUM_W-1:0]            rem_q;
	logic [qpht_pkg::DCNT_W-1:0] div_cnt_q;
	logic [SUM_W:0]              rem_try;

	logic [SLOT_W-1:0]           slot_q;
	logic [SLOT_W-1:0]           start_q;
	logic [SLOT_W-1:0]           inc_q;
	logic [SLOT_W-1:0]           i_q;
	logic [SLOT_W-1:0]           clr_q;

	logic [SUM_W-1:0]            inc_p2;
	logic [SUM_W-1:0]            inc_a;
	logic [SUM_W-1:0]            inc_b;
	logic [SUM_W-1:0]            slot_sum;
	logic [SUM_W-1:0]            slot_nx;

	logic                        ram_we;
	logic [SLOT_W-1:0]           ram_waddr;
	logic [qpht_pkg::ENTRY_W-1:0] ram_wdata;
	logic [qpht_pkg::ENTRY_W-1:0] ram_rdata;

	logic [qpht_pkg::OUT_W-1:0]  out_slot_q;
	logic [qpht_pkg::OUT_W-1:0]  out_probe_q;
	qpht_pkg::status_t           out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= qpht_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			table_size_q <= cfg_wdata;
		end
	end

	// size in use: 0 acts as 1, above SLOTS acts as SLOTS
	always_comb begin
		if (table_size_q == '0) begin
			n = SUM_W'(1);
		end else if (32'(table_size_q) > qpht_pkg::SLOTS) begin
			n = SUM_W'(qpht_pkg::SLOTS);
		end else begin
			n = SUM_W'(table_size_q);
		end
	end

	// restoring remainder, MSB first, one key bit per cycle
	assign rem_try = {rem_q, key_sh_q[KB-1]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= s_axis_tdata[KB-1:0];
			key_sh_q <= s_axis_tdata[KB-1:0];
			rem_q    <= '0;
		end else if (cmd.div_run) begin
			key_sh_q <= {key_sh_q[KB-2:0], 1'b0};
			if (rem_try >= {1'b0, n}) begin
				rem_q <= SUM_W'(rem_try - {1'b0, n});
			end else begin
				rem_q <= SUM_W'(rem_try);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.load) begin
			div_cnt_q <= '0;
		end else if (cmd.div_run) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// inc tracks 2*i mod n; each reduction step works on values below 3n
	always_comb begin
		inc_p2   = {1'b0, inc_q} + SUM_W'(2);
		inc_a    = (inc_p2 >= n) ? inc_p2 - n : inc_p2;
		inc_b    = (inc_a >= n) ? inc_a - n : inc_a;
		slot_sum = {1'b0, slot_q} + inc_b;
		slot_nx  = (slot_sum >= n) ? slot_sum - n : slot_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else if (cmd.load || cmd.probe_init) begin
			i_q <= '0;
		end else if (cmd.advance) begin
			i_q <= i_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.probe_init) begin
			slot_q  <= SLOT_W'(rem_q);
			start_q <= SLOT_W'(rem_q);
			inc_q   <= '0;
		end else if (cmd.advance) begin
			slot_q <= SLOT_W'(slot_nx);
			inc_q  <= SLOT_W'(inc_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign ram_we    = cmd.clr_wr | cmd.wr_insert | cmd.wr_delete;
	assign ram_waddr = cmd.clr_wr ? clr_q : slot_q;
	assign ram_wdata = {cmd.wr_insert, key_q};

	qpht_ram #(
		.WIDTH (qpht_pkg::ENTRY_W),
		.DEPTH (qpht_pkg::SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		stat.div_done    = (div_cnt_q == qpht_pkg::DCNT_W'(KB));
		stat.occ         = ram_rdata[KB];
		stat.match       = ram_rdata[KB] && (ram_rdata[KB-1:0] == key_q);
		stat.at_start    = (slot_q == start_q);
		stat.first_probe = (i_q == '0);
		stat.clr_last    = (clr_q == SLOT_W'(qpht_pkg::SLOTS - 1));
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= cmd.res_status;
			out_probe_q  <= qpht_pkg::OUT_W'(i_q);
			if (cmd.res_status == qpht_pkg::ST_DONE) begin
				out_slot_q <= qpht_pkg::OUT_W'(slot_q);
			end else begin
				out_slot_q <= '0;
			end
		end
	end

	assign m_axis_tdata = {4'b0, out_probe_q, out_slot_q};
	assign m_axis_tuser = {6'b0, out_status_q};

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> ({1'b0, slot_q} < n) && ({1'b0, inc_q} < n))
		else $error("probe slot or increment not below table size");

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_run |-> (rem_q < n))
		else $error("partial remainder not below table size");

endmodule

[design/qpht_ctrl.sv]
// qpht_ctrl: controller of the hash table: clear sweep, handshakes, modulo
// and probe sequencing, and the per-command decisions.
// Depends on qpht_pkg.

module qpht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tuser,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  qpht_pkg::dp_stat_t stat,
	output qpht_pkg::dp_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_DIV   = 6'b000100,
		S_READ  = 6'b001000,
		S_CHECK = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	qpht_pkg::op_t     op_q;
	qpht_pkg::status_t res_q;
	qpht_pkg::status_t res_d;
	logic              m_tvalid_q;
	logic              take;
	logic              wrap;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign take          = s_axis_tvalid && s_axis_tready;
	// back at the first slot after at least one step
	assign wrap          = stat.at_start && !stat.first_probe;

	always_comb begin
		state_d        = state_q;
		res_d          = res_q;
		cmd            = '0;
		cmd.res_status = res_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (take) begin
					cmd.load = 1'b1;
					unique case (s_axis_tuser[1:0])
						qpht_pkg::OP_INSERT, qpht_pkg::OP_SEARCH,
						qpht_pkg::OP_DELETE: state_d = S_DIV;
						default: begin
							res_d   = qpht_pkg::ST_MISSING;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.probe_init = 1'b1;
					state_d        = S_READ;
				end else begin
					cmd.div_run = 1'b1;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_CHECK;
			end
			S_CHECK: begin
				state_d = S_RESP;
				if (op_q == qpht_pkg::OP_INSERT) begin
					if (!stat.occ) begin
						cmd.wr_insert = 1'b1;
						res_d         = qpht_pkg::ST_DONE;
					end else if (wrap) begin
						res_d = qpht_pkg::ST_FULL;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_READ;
					end
				end else begin
					if (wrap || (!stat.occ && !stat.first_probe)) begin
						res_d = qpht_pkg::ST_MISSING;
					end else if (stat.match) begin
						cmd.wr_delete = (op_q == qpht_pkg::OP_DELETE);
						res_d         = qpht_pkg::ST_DONE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_READ;
					end
				end
			end
			S_RESP: begin
				if (!m_tvalid_q || m_axis_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			op_q       <= qpht_pkg::OP_INSERT;
			res_q      <= qpht_pkg::ST_DONE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.load) begin
				op_q <= qpht_pkg::op_t'(s_axis_tuser[1:0]);
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	a_no_step_past_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> !wrap)
		else $error("probe advanced after returning to first slot");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.wr_insert, cmd.wr_delete}))
		else $error("more than one RAM write source");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid_q && (state_q == S_IDLE))
		else $error("result load did not raise tvalid");

endmodule

[design/quadratic_probe_hash_table.sv]
// quadratic_probe_hash_table: top level, open-addressing hash table with
// quadratic probing. Depends on qpht_pkg, qpht_ctrl, qpht_dp (and qpht_ram).
//
//   channel  | dir | tdata                          | tuser
//   ---------+-----+--------------------------------+------------------
//   s_axis   | in  | [30:0] key                     | [1:0] command
//   m_axis   | out | [9:0] slot_index,              | [1:0] status
//            |     | [19:10] probe_count            |
//   cfg      | in  | cfg_wdata = table_size (11 b)  | -
//
// After reset a sweep over every slot clears the occupied map; no transaction
// is taken on s_axis until it ends. An operation runs through these steps up to
// the result load: accept, 31 modulo steps (one key bit each), probe setup,
// a RAM read and a decision per slot visited, and the result load. An unknown
// command goes from accept straight to the result load. A new transaction is taken
// while the result register still waits on m_axis_tready; the next result load stalls.

module quadratic_probe_hash_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [qpht_pkg::SIZE_W-1:0] cfg_wdata,       // table_size
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,    // [30:0] key
	input  logic [7:0]                  s_axis_tuser,    // [1:0] command
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [23:0]                 m_axis_tdata,    // [9:0] slot_index, [19:10] probe_count
	output logic [7:0]                  m_axis_tuser     // [1:0] status
);

	qpht_pkg::dp_cmd_t  cmd;
	qpht_pkg::dp_stat_t stat;

	qpht_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	qpht_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tdata (s_axis_tdata),
		.cmd          (cmd),
		.stat         (stat),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule
